// ===== hw/rtl/se3pid_pkg.sv =====
// Shared types, constants, gain tables and helper functions of the SE(3) pose PID controller.
`timescale 1ns / 1ps
package se3pid_pkg;

	localparam int POS_W  = 32;
	localparam int QUAT_W = 16;
	localparam int QF     = 14;
	localparam int SUM_W  = 48;

	// Shared multiplier operand and product widths.
	localparam int MA_W = 34;
	localparam int MB_W = 28;
	localparam int MP_W = MA_W + MB_W;

	localparam int ROT_W   = 22;
	localparam int RT_W    = 2 * QUAT_W + 3;
	localparam int MACC_W  = 36;
	localparam int IACC_W  = 76;
	localparam int TOT_W   = 48;
	localparam int MERR_SH = 2 * QF - 16;
	localparam int P_SH    = 24;
	localparam int I_SH    = 40;
	localparam int SUM_SPLIT = 24;

	localparam logic signed [RT_W-1:0] ROT_ONE  = RT_W'(1) << (2 * QF);
	localparam logic signed [RT_W-1:0] ROT_HALF = RT_W'(1) << (QF - 1);

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [QUAT_W-1:0] quat_t;

	// Quaternion elements are ordered w, x, y, z at indexes 0 to 3.
	typedef struct packed {
		logic           sample_ok;
		pos_t  [2:0]    pos;
		quat_t [3:0]    quat;
	} item_t;

	typedef struct packed {
		pos_t  [2:0]    pos;
		quat_t [3:0]    quat;
		logic           valid;
	} target_t;

	typedef enum logic [2:0] {
		OP_QPROD,
		OP_MERR,
		OP_IH,
		OP_IL,
		OP_P,
		OP_D
	} op_t;

	typedef struct packed {
		logic                   valid;
		op_t                    op;
		logic [1:0]             grp;
		logic [3:0]             idx;
		logic signed [MA_W-1:0] a;
		logic signed [MB_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                   valid;
		op_t                    op;
		logic [1:0]             grp;
		logic [3:0]             idx;
		logic signed [MP_W-1:0] p;
	} mul_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_QPROD,
		S_QWAIT,
		S_ROT,
		S_MERR,
		S_AXIS,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RF_ONE,
		RF_ADD,
		RF_SUB
	} rform_t;

	typedef struct packed {
		logic [3:0] pa;
		logic [3:0] pb;
		rform_t     form;
	} rot_sel_t;

	typedef struct packed {
		logic [3:0] rci;
		logic [3:0] rdi;
		logic       neg;
	} merr_sel_t;

	// Quaternion products in order: xx yy zz xy xz yz wx wy wz; returns {ia, ib}.
	function automatic logic [3:0] qpair(input logic [3:0] j);
		logic [3:0] r;
		case (j)
			4'd0:    r = {2'd1, 2'd1};
			4'd1:    r = {2'd2, 2'd2};
			4'd2:    r = {2'd3, 2'd3};
			4'd3:    r = {2'd1, 2'd2};
			4'd4:    r = {2'd1, 2'd3};
			4'd5:    r = {2'd2, 2'd3};
			4'd6:    r = {2'd0, 2'd1};
			4'd7:    r = {2'd0, 2'd2};
			default: r = {2'd0, 2'd3};
		endcase
		return r;
	endfunction

	// Row-major rotation entry built from two of the products above.
	function automatic rot_sel_t rot_form(input logic [3:0] e);
		rot_sel_t r;
		case (e)
			4'd0:    r = '{pa: 4'd1, pb: 4'd2, form: RF_ONE};
			4'd1:    r = '{pa: 4'd3, pb: 4'd8, form: RF_SUB};
			4'd2:    r = '{pa: 4'd4, pb: 4'd7, form: RF_ADD};
			4'd3:    r = '{pa: 4'd3, pb: 4'd8, form: RF_ADD};
			4'd4:    r = '{pa: 4'd0, pb: 4'd2, form: RF_ONE};
			4'd5:    r = '{pa: 4'd5, pb: 4'd6, form: RF_SUB};
			4'd6:    r = '{pa: 4'd4, pb: 4'd7, form: RF_SUB};
			4'd7:    r = '{pa: 4'd5, pb: 4'd6, form: RF_ADD};
			default: r = '{pa: 4'd0, pb: 4'd1, form: RF_ONE};
		endcase
		return r;
	endfunction

	// Term t of orientation error entry ent: (2,1), (0,2) or (1,0) of Rc'Rd - Rc Rd'.
	function automatic merr_sel_t merr_term(input logic [1:0] ent, input logic [3:0] t);
		merr_sel_t r;
		logic [3:0] i;
		logic [3:0] j;
		logic [3:0] k;
		case (ent)
			2'd0:    begin i = 4'd2; j = 4'd1; end
			2'd1:    begin i = 4'd0; j = 4'd2; end
			default: begin i = 4'd1; j = 4'd0; end
		endcase
		if (t < 4'd3) begin
			r.rci = 4'(t * 4'd3 + i);
			r.rdi = 4'(t * 4'd3 + j);
			r.neg = 1'b0;
		end else begin
			k = 4'(t - 4'd3);
			r.rci = 4'(i * 4'd3 + k);
			r.rdi = 4'(j * 4'd3 + k);
			r.neg = 1'b1;
		end
		return r;
	endfunction

	function automatic logic signed [MB_W-1:0] gain_p(input logic [2:0] ax);
		logic signed [MB_W-1:0] g;
		case (ax)
			3'd0, 3'd1, 3'd2: g = MB_W'(83886080);
			3'd3, 3'd4:       g = MB_W'(1342177);
			default:          g = MB_W'(13421773);
		endcase
		return g;
	endfunction

	function automatic logic signed [MB_W-1:0] gain_i(input logic [2:0] ax);
		logic signed [MB_W-1:0] g;
		case (ax)
			3'd0, 3'd1, 3'd2: g = MB_W'(54975581);
			default:          g = MB_W'(5497558);
		endcase
		return g;
	endfunction

	function automatic logic signed [MB_W-1:0] gain_d(input logic [2:0] ax);
		logic signed [MB_W-1:0] g;
		case (ax)
			3'd0, 3'd1: g = MB_W'(3960);
			3'd2:       g = MB_W'(4500);
			3'd3, 3'd4: g = MB_W'(63);
			default:    g = MB_W'(720);
		endcase
		return g;
	endfunction

	// Shift right by sh with rounding half away from zero.
	function automatic logic signed [MP_W-1:0] rnd_p(input logic signed [MP_W-1:0] v,
			input int unsigned sh);
		logic signed [MP_W-1:0] h;
		h = MP_W'(1) << (sh - 1);
		if (v[MP_W-1])
			h = h - MP_W'(1);
		return (v + h) >>> sh;
	endfunction

	function automatic logic signed [IACC_W-1:0] rnd_i(input logic signed [IACC_W-1:0] v,
			input int unsigned sh);
		logic signed [IACC_W-1:0] h;
		h = IACC_W'(1) << (sh - 1);
		if (v[IACC_W-1])
			h = h - IACC_W'(1);
		return (v + h) >>> sh;
	endfunction

endpackage

// ===== hw/rtl/se3pid_mul.sv =====
// Shared signed multiplier with a registered product and a request tag that travels along.
`timescale 1ns / 1ps
module se3pid_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  se3pid_pkg::mul_req_t  req,
	output se3pid_pkg::mul_rsp_t  rsp
);
	import se3pid_pkg::*;

	logic                   valid_s1;
	op_t                    op_s1;
	logic [1:0]             grp_s1;
	logic [3:0]             idx_s1;
	logic signed [MP_W-1:0] p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= req.op;
		grp_s1 <= req.grp;
		idx_s1 <= req.idx;
		p_s1   <= MP_W'(req.a) * MP_W'(req.b);
	end

	assign rsp = '{valid: valid_s1, op: op_s1, grp: grp_s1, idx: idx_s1, p: p_s1};

endmodule

// ===== hw/rtl/se3pid_core.sv =====
// Sequencer and datapath that run one control tick through the shared multiplier.
`timescale 1ns / 1ps
module se3pid_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  se3pid_pkg::item_t       item,
	input  se3pid_pkg::target_t     tgt,
	output logic                    res_valid,
	input  logic                    res_ready,
	output se3pid_pkg::pos_t [5:0]  res
);
	import se3pid_pkg::*;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [1:0] grp_q, grp_d;
	logic [2:0] sub_q, sub_d;
	logic       in_fire;

	item_t                    meas_q;
	logic signed [31:0]       prod_q [2][9];
	logic signed [ROT_W-1:0]  rc_q [9];
	logic signed [ROT_W-1:0]  rd_q [9];
	logic signed [ROT_W-1:0]  rot_d [2][9];
	logic signed [MACC_W-1:0] macc_q [3];
	logic signed [SUM_W-1:0]  sum_q [6];
	pos_t                     last_q [6];
	pos_t                     e_q;
	logic signed [POS_W:0]    d_q;
	logic signed [IACC_W-1:0] iacc_q;
	logic signed [TOT_W-1:0]  tot_q;
	logic signed [TOT_W-1:0]  irnd_q;
	pos_t [5:0]               res_q;

	mul_req_t req;
	mul_rsp_t rsp;

	logic [2:0]               ax;
	logic [1:0]               ax2;
	logic [1:0]               mi;
	logic signed [POS_W:0]    df;
	logic signed [MACC_W-1:0] ev;
	pos_t                     e_c;
	logic signed [SUM_W:0]    ns;
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [POS_W:0]    d_c;
	logic signed [TOT_W:0]    fin;
	pos_t                     fin_c;
	logic signed [MACC_W-1:0] mterm;
	merr_sel_t                msel;

	assign ax       = cnt_q[2:0];
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign res_valid = (state_q == S_DONE);
	assign res      = res_q;

	se3pid_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			grp_q   <= '0;
			sub_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			grp_q   <= grp_d;
			sub_q   <= sub_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		grp_d   = grp_q;
		sub_d   = sub_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire && tgt.valid && item.sample_ok) begin
					state_d = S_QPROD;
					cnt_d   = '0;
					grp_d   = '0;
				end
			end
			S_QPROD: begin
				if (cnt_q == 4'd8) begin
					cnt_d = '0;
					if (grp_q == 2'd1)
						state_d = S_QWAIT;
					else
						grp_d = 2'd1;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			S_QWAIT: state_d = S_ROT;
			S_ROT: begin
				state_d = S_MERR;
				cnt_d   = '0;
				grp_d   = '0;
			end
			S_MERR: begin
				if (cnt_q == 4'd5) begin
					cnt_d = '0;
					if (grp_q == 2'd2) begin
						state_d = S_AXIS;
						sub_d   = '0;
					end else begin
						grp_d = grp_q + 2'd1;
					end
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			S_AXIS: begin
				if (sub_q == 3'd6) begin
					sub_d = '0;
					if (cnt_q == 4'd5)
						state_d = S_DONE;
					else
						cnt_d = cnt_q + 4'd1;
				end else begin
					sub_d = sub_q + 3'd1;
				end
			end
			S_DONE: begin
				if (res_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Multiplier requests.
	always_comb begin
		logic [3:0] qp;
		merr_sel_t  rs;
		quat_t      qa;
		quat_t      qb;
		req = '0;
		qp  = qpair(cnt_q);
		rs  = merr_term(grp_q, cnt_q);
		qa  = grp_q[0] ? tgt.quat[qp[3:2]] : meas_q.quat[qp[3:2]];
		qb  = grp_q[0] ? tgt.quat[qp[1:0]] : meas_q.quat[qp[1:0]];
		req.grp = grp_q;
		req.idx = cnt_q;
		case (state_q)
			S_QPROD: begin
				req.valid = 1'b1;
				req.op    = OP_QPROD;
				req.a     = MA_W'(qa);
				req.b     = MB_W'(qb);
			end
			S_MERR: begin
				req.valid = 1'b1;
				req.op    = OP_MERR;
				req.a     = MA_W'(rc_q[rs.rci]);
				req.b     = MB_W'(rd_q[rs.rdi]);
			end
			S_AXIS: begin
				case (sub_q)
					3'd1: begin
						req.valid = 1'b1;
						req.op    = OP_IH;
						req.a     = MA_W'($signed(sum_q[ax][SUM_W-1:SUM_SPLIT]));
						req.b     = gain_i(ax);
					end
					3'd2: begin
						req.valid = 1'b1;
						req.op    = OP_IL;
						req.a     = MA_W'({1'b0, sum_q[ax][SUM_SPLIT-1:0]});
						req.b     = gain_i(ax);
					end
					3'd3: begin
						req.valid = 1'b1;
						req.op    = OP_P;
						req.a     = MA_W'(e_q);
						req.b     = gain_p(ax);
					end
					3'd4: begin
						req.valid = 1'b1;
						req.op    = OP_D;
						req.a     = MA_W'(d_q);
						req.b     = gain_d(ax);
					end
					default: req.valid = 1'b0;
				endcase
			end
			default: req.valid = 1'b0;
		endcase
	end

	// Rotation matrices of both quaternions, built from the stored products.
	always_comb begin
		rot_sel_t                fs;
		logic signed [RT_W-1:0]  ta;
		logic signed [RT_W-1:0]  tb;
		logic signed [RT_W-1:0]  tt;
		for (int q = 0; q < 2; q++) begin
			for (int e = 0; e < 9; e++) begin
				fs = rot_form(4'(e));
				ta = RT_W'(prod_q[q][fs.pa]);
				tb = RT_W'(prod_q[q][fs.pb]);
				case (fs.form)
					RF_ONE:  tt = ROT_ONE - ((ta + tb) <<< 1);
					RF_ADD:  tt = (ta + tb) <<< 1;
					default: tt = (ta - tb) <<< 1;
				endcase
				rot_d[q][e] = ROT_W'((tt + ROT_HALF) >>> QF);
			end
		end
	end

	// Per-axis error, integral and difference; the final sum of the three terms.
	always_comb begin
		ax2 = (ax < 3'd3) ? ax[1:0] : 2'd0;
		mi  = 2'(ax - 3'd3);
		df  = (POS_W+1)'($signed(tgt.pos[ax2])) - (POS_W+1)'($signed(meas_q.pos[ax2]));
		ev  = (ax < 3'd3) ? MACC_W'(df) : macc_q[mi];
		if (ev > POS_MAX)
			e_c = POS_MAX;
		else if (ev < POS_MIN)
			e_c = POS_MIN;
		else
			e_c = POS_W'(ev);
		ns = (SUM_W+1)'(sum_q[ax]) + (SUM_W+1)'(e_c);
		if (ns > SUM_MAX)
			sum_c = SUM_MAX;
		else if (ns < SUM_MIN)
			sum_c = SUM_MIN;
		else
			sum_c = SUM_W'(ns);
		d_c = (POS_W+1)'(e_c) - (POS_W+1)'(last_q[ax]);
		fin = (TOT_W+1)'(tot_q) + (TOT_W+1)'(irnd_q);
		if (fin > POS_MAX)
			fin_c = POS_MAX;
		else if (fin < POS_MIN)
			fin_c = POS_MIN;
		else
			fin_c = POS_W'(fin);
		msel  = merr_term(rsp.grp, rsp.idx);
		mterm = MACC_W'(rnd_p(rsp.p, MERR_SH));
	end

	// Controller state: integral and previous error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 6; a++) begin
				sum_q[a]  <= '0;
				last_q[a] <= '0;
			end
		end else begin
			if (in_fire && !tgt.valid) begin
				for (int a = 0; a < 6; a++)
					sum_q[a] <= '0;
			end
			if (state_q == S_AXIS && sub_q == 3'd0) begin
				sum_q[ax]  <= sum_c;
				last_q[ax] <= e_c;
			end
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (in_fire)
			meas_q <= item;
		if (state_q == S_ROT) begin
			for (int e = 0; e < 9; e++) begin
				rc_q[e] <= rot_d[0][e];
				rd_q[e] <= rot_d[1][e];
			end
			for (int k = 0; k < 3; k++)
				macc_q[k] <= '0;
		end
		if (state_q == S_AXIS) begin
			case (sub_q)
				3'd0: begin
					e_q <= e_c;
					d_q <= d_c;
				end
				3'd4: irnd_q <= TOT_W'(rnd_i(iacc_q, I_SH));
				3'd6: res_q[ax] <= fin_c;
				default: ;
			endcase
		end
		if (rsp.valid) begin
			case (rsp.op)
				OP_QPROD: prod_q[rsp.grp[0]][rsp.idx] <= rsp.p[31:0];
				OP_MERR: begin
					if (msel.neg)
						macc_q[rsp.grp] <= macc_q[rsp.grp] - mterm;
					else
						macc_q[rsp.grp] <= macc_q[rsp.grp] + mterm;
				end
				OP_IH:   iacc_q <= IACC_W'(rsp.p) <<< SUM_SPLIT;
				OP_IL:   iacc_q <= iacc_q + IACC_W'(rsp.p);
				OP_P:    tot_q  <= TOT_W'(rnd_p(rsp.p, P_SH));
				OP_D:    tot_q  <= tot_q + TOT_W'(rsp.p);
				default: ;
			endcase
		end
	end

	// A result is only ever produced against a valid target.
	a_res_needs_target: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> tgt.valid)
		else $error("result offered without a valid target");

	// No product may still be in flight once the sequencer is back at rest.
	a_no_stray_product: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !rsp.valid)
		else $error("multiplier product arrived while idle");

	// A request taken while waiting for a target clears the integral.
	a_wait_clears_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !tgt.valid) |=> (sum_q[0] == '0 && sum_q[5] == '0))
		else $error("integral not cleared while waiting for target");

endmodule

// ===== hw/rtl/se3_pose_pid_controller.sv =====
// Top level of the SE(3) pose PID controller: register port, request and result channels.
`timescale 1ns / 1ps
// The block takes one request per control tick on the in_valid/in_ready channel: a flag
// that says the sample is good, a measured position in Q16.16 and a measured
// orientation quaternion in Q1.14. The target pose and the target-valid flag sit in
// registers behind the APB port (byte addresses 0x00 to 0x1c, pready always high).
// For each good sample with a valid target it returns one six-axis wrench on the
// out_valid/out_ready channel, each axis saturated to Q16.16.
// A request without a valid target returns nothing and clears the integral; a request
// with a failed sample returns nothing and changes nothing. Both leave the core idle.
// A tick steps through the quaternion products, the rotation matrices, the orientation
// error and the six axes inside the core, and the result then passes through the output
// register to the outputs. The pace is set by the single shared multiplier, which forms
// 18 quaternion products, 18 rotation products and four gain products per axis one after
// another under the sequencer. The core takes no new request until its tick is done.
// The result sits in an output register, so a new request is accepted while the previous
// wrench waits for out_ready; if the core finishes again before that, it holds its
// result until the output register frees up.
// Reset clears the integral and the previous error, sets the target to the origin with
// the identity orientation and marks the target as not yet valid.
module se3_pose_pid_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [4:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                sample_ok,
	input  logic signed [se3pid_pkg::POS_W-1:0]  meas_pos_x,
	input  logic signed [se3pid_pkg::POS_W-1:0]  meas_pos_y,
	input  logic signed [se3pid_pkg::POS_W-1:0]  meas_pos_z,
	input  logic signed [se3pid_pkg::QUAT_W-1:0] meas_quat_w,
	input  logic signed [se3pid_pkg::QUAT_W-1:0] meas_quat_x,
	input  logic signed [se3pid_pkg::QUAT_W-1:0] meas_quat_y,
	input  logic signed [se3pid_pkg::QUAT_W-1:0] meas_quat_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [se3pid_pkg::POS_W-1:0]  force_x,
	output logic signed [se3pid_pkg::POS_W-1:0]  force_y,
	output logic signed [se3pid_pkg::POS_W-1:0]  force_z,
	output logic signed [se3pid_pkg::POS_W-1:0]  torque_x,
	output logic signed [se3pid_pkg::POS_W-1:0]  torque_y,
	output logic signed [se3pid_pkg::POS_W-1:0]  torque_z
);
	import se3pid_pkg::*;

	localparam logic [2:0] REG_POS_X  = 3'd0;
	localparam logic [2:0] REG_POS_Y  = 3'd1;
	localparam logic [2:0] REG_POS_Z  = 3'd2;
	localparam logic [2:0] REG_QUAT_W = 3'd3;
	localparam logic [2:0] REG_QUAT_X = 3'd4;
	localparam logic [2:0] REG_QUAT_Y = 3'd5;
	localparam logic [2:0] REG_QUAT_Z = 3'd6;
	localparam logic [2:0] REG_VALID  = 3'd7;

	target_t    tgt_q;
	item_t      item;
	logic       cfg_wr;
	logic [2:0] reg_idx;

	logic       res_valid;
	logic       res_ready;
	pos_t [5:0] res;
	logic       out_valid_q;
	pos_t [5:0] out_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Target registers. The user must write them only while the core is at rest; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q.pos   <= '0;
			tgt_q.quat  <= {{3{QUAT_W'(0)}}, QUAT_W'(16384)};
			tgt_q.valid <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_POS_X:  tgt_q.pos[0]  <= pwdata;
				REG_POS_Y:  tgt_q.pos[1]  <= pwdata;
				REG_POS_Z:  tgt_q.pos[2]  <= pwdata;
				REG_QUAT_W: tgt_q.quat[0] <= pwdata[QUAT_W-1:0];
				REG_QUAT_X: tgt_q.quat[1] <= pwdata[QUAT_W-1:0];
				REG_QUAT_Y: tgt_q.quat[2] <= pwdata[QUAT_W-1:0];
				REG_QUAT_Z: tgt_q.quat[3] <= pwdata[QUAT_W-1:0];
				REG_VALID:  tgt_q.valid   <= pwdata[0];
				default:    ;
			endcase
		end
	end

	// Register read-back; quaternion and flag registers read zero in their upper bits.
	always_comb begin
		case (reg_idx)
			REG_POS_X:  prdata = tgt_q.pos[0];
			REG_POS_Y:  prdata = tgt_q.pos[1];
			REG_POS_Z:  prdata = tgt_q.pos[2];
			REG_QUAT_W: prdata = {16'h0000, tgt_q.quat[0]};
			REG_QUAT_X: prdata = {16'h0000, tgt_q.quat[1]};
			REG_QUAT_Y: prdata = {16'h0000, tgt_q.quat[2]};
			REG_QUAT_Z: prdata = {16'h0000, tgt_q.quat[3]};
			REG_VALID:  prdata = {31'h0, tgt_q.valid};
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		item.sample_ok = sample_ok;
		item.pos[0]    = meas_pos_x;
		item.pos[1]    = meas_pos_y;
		item.pos[2]    = meas_pos_z;
		item.quat[0]   = meas_quat_w;
		item.quat[1]   = meas_quat_x;
		item.quat[2]   = meas_quat_y;
		item.quat[3]   = meas_quat_z;
	end

	se3pid_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.item      (item),
		.tgt       (tgt_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: the core hands over whenever the register is empty or draining.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign force_x   = out_q[0];
	assign force_y   = out_q[1];
	assign force_z   = out_q[2];
	assign torque_x  = out_q[3];
	assign torque_y  = out_q[4];
	assign torque_z  = out_q[5];

endmodule

// ===== tb/se3pid_tb_pkg.sv =====
// Register indexes of the pose controller shared by the testbench files.
`timescale 1ns / 1ps
package se3pid_tb_pkg;

	typedef enum logic [2:0] {
		REG_POS_X,
		REG_POS_Y,
		REG_POS_Z,
		REG_QUAT_W,
		REG_QUAT_X,
		REG_QUAT_Y,
		REG_QUAT_Z,
		REG_TGT_VALID
	} reg_idx_t;

	typedef logic [5:0][31:0] wrench_t;

endpackage

// ===== tb/se3pid_checker.sv =====
// Wrench predictor and result checker for the SE(3) pose PID controller.
`timescale 1ns / 1ps
module se3pid_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               sample_ok,
	input  logic signed [31:0] meas_pos_x,
	input  logic signed [31:0] meas_pos_y,
	input  logic signed [31:0] meas_pos_z,
	input  logic signed [15:0] meas_quat_w,
	input  logic signed [15:0] meas_quat_x,
	input  logic signed [15:0] meas_quat_y,
	input  logic signed [15:0] meas_quat_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	input  logic signed [31:0] torque_x,
	input  logic signed [31:0] torque_y,
	input  logic signed [31:0] torque_z,
	output int                 fail_count,
	output int                 wrench_pending
);
	import se3pid_tb_pkg::*;

	localparam longint CLAMP = longint'(1) << 59;
	localparam longint KP_Q24[6] = '{83886080, 83886080, 83886080, 1342177, 1342177, 13421773};
	localparam longint KI_Q40[6] = '{54975581, 54975581, 54975581, 5497558, 5497558, 5497558};
	localparam longint KD_INT[6] = '{3960, 3960, 4500, 63, 63, 720};

	logic signed [31:0] tgt_pos[3];
	logic signed [15:0] tgt_quat[4];
	logic               tgt_valid;
	longint             prev_err[6];
	longint             err_acc[6];
	wrench_t            wrench_q[$];
	string              axis_name[6] = '{"force_x", "force_y", "force_z",
		"torque_x", "torque_y", "torque_z"};

	assign wrench_pending = wrench_q.size();

	function automatic longint sat_to(longint v, int w);
		longint hi;
		hi = (longint'(1) << (w - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	// Scaled product, rounded half away from zero, magnitude limited to 2^59.
	function automatic longint scaled_mul(longint a, longint b, int sh);
		logic [127:0] ua;
		logic [127:0] ub;
		logic [127:0] p;
		bit           neg;
		ua = {64'd0, (a < 0) ? -a : a};
		ub = {64'd0, (b < 0) ? -b : b};
		neg = (a < 0) != (b < 0);
		p = ua * ub;
		if (sh > 0)
			p = (p + (128'd1 << (sh - 1))) >> sh;
		if (p > 128'(CLAMP))
			p = 128'(CLAMP);
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	// Rotation matrix of an unnormalized quaternion, entries with 14 fraction bits.
	function automatic void quat_rot(longint w, longint x, longint y, longint z,
			output longint r[9]);
		longint one;
		longint t[9];
		one = longint'(1) << 28;
		t[0] = one - 2 * (y * y + z * z);
		t[1] = 2 * (x * y - w * z);
		t[2] = 2 * (x * z + w * y);
		t[3] = 2 * (x * y + w * z);
		t[4] = one - 2 * (x * x + z * z);
		t[5] = 2 * (y * z - w * x);
		t[6] = 2 * (x * z - w * y);
		t[7] = 2 * (y * z + w * x);
		t[8] = one - 2 * (x * x + y * y);
		for (int k = 0; k < 9; k++)
			r[k] = (t[k] + (longint'(1) << 13)) >>> 14;
	endfunction

	// Entry (i,j) of Rc'Rd - Rc Rd' in Q16.16.
	function automatic longint rot_err(longint rc[9], longint rd[9], int i, int j);
		longint acc;
		acc = 0;
		for (int k = 0; k < 3; k++) begin
			acc += scaled_mul(rc[k*3+i], rd[k*3+j], 12);
			acc -= scaled_mul(rc[i*3+k], rd[j*3+k], 12);
		end
		return acc;
	endfunction

	task automatic predict_wrench();
		longint  rc[9];
		longint  rd[9];
		longint  e[6];
		longint  d;
		longint  total;
		wrench_t w;
		if (!tgt_valid) begin
			foreach (err_acc[a])
				err_acc[a] = 0;
			return;
		end
		if (!sample_ok)
			return;
		e[0] = sat_to(longint'(tgt_pos[0]) - longint'(meas_pos_x), 32);
		e[1] = sat_to(longint'(tgt_pos[1]) - longint'(meas_pos_y), 32);
		e[2] = sat_to(longint'(tgt_pos[2]) - longint'(meas_pos_z), 32);
		quat_rot(meas_quat_w, meas_quat_x, meas_quat_y, meas_quat_z, rc);
		quat_rot(tgt_quat[0], tgt_quat[1], tgt_quat[2], tgt_quat[3], rd);
		e[3] = sat_to(rot_err(rc, rd, 2, 1), 32);
		e[4] = sat_to(rot_err(rc, rd, 0, 2), 32);
		e[5] = sat_to(rot_err(rc, rd, 1, 0), 32);
		for (int a = 0; a < 6; a++) begin
			err_acc[a] = sat_to(err_acc[a] + e[a], 48);
			d = e[a] - prev_err[a];
			prev_err[a] = e[a];
			total = scaled_mul(e[a], KP_Q24[a], 24) + scaled_mul(err_acc[a], KI_Q40[a], 40)
				+ scaled_mul(d, KD_INT[a], 0);
			w[a] = 32'(sat_to(total, 32));
		end
		wrench_q.insert(wrench_q.size(), w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		wrench_t got;
		wrench_t want;
		if (!arst_n) begin
			tgt_pos = '{0, 0, 0};
			tgt_quat = '{16384, 0, 0, 0};
			tgt_valid = 1'b0;
			foreach (prev_err[a]) begin
				prev_err[a] = 0;
				err_acc[a] = 0;
			end
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_POS_X:     tgt_pos[0] = pwdata;
					REG_POS_Y:     tgt_pos[1] = pwdata;
					REG_POS_Z:     tgt_pos[2] = pwdata;
					REG_QUAT_W:    tgt_quat[0] = pwdata[15:0];
					REG_QUAT_X:    tgt_quat[1] = pwdata[15:0];
					REG_QUAT_Y:    tgt_quat[2] = pwdata[15:0];
					REG_QUAT_Z:    tgt_quat[3] = pwdata[15:0];
					REG_TGT_VALID: tgt_valid = pwdata[0];
					default:       ;
				endcase
			end
			if (in_valid && in_ready)
				predict_wrench();
			if (out_valid && out_ready) begin
				got = {torque_z, torque_y, torque_x, force_z, force_y, force_x};
				if (wrench_q.size() == 0) begin
					$error("wrench returned with none expected");
					fail_count++;
				end else begin
					want = wrench_q.pop_front();
					for (int a = 0; a < 6; a++)
						if (got[a] !== want[a]) begin
							$error("%s expected %0d actual %0d", axis_name[a],
								$signed(want[a]), $signed(got[a]));
							fail_count++;
						end
				end
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top of the SE(3) pose PID controller: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb;
	import se3pid_tb_pkg::*;

	localparam int IDLE_WAIT  = 100;    // cycles to let the core settle after the last wrench
	localparam int STALL_LIMIT = 20000; // cycles without any handshake before giving up

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               sample_ok;
	logic signed [31:0] meas_pos_x, meas_pos_y, meas_pos_z;
	logic signed [15:0] meas_quat_w, meas_quat_x, meas_quat_y, meas_quat_z;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] force_x, force_y, force_z, torque_x, torque_y, torque_z;
	int                 fail_count;
	int                 wrench_pending;
	int                 quiet_cycles;
	bit                 no_gaps;

	// Current target as written, so that random positions can be placed near it.
	logic signed [31:0] cur_pos[3];

	se3_pose_pid_controller uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .sample_ok(sample_ok),
		.meas_pos_x(meas_pos_x), .meas_pos_y(meas_pos_y), .meas_pos_z(meas_pos_z),
		.meas_quat_w(meas_quat_w), .meas_quat_x(meas_quat_x),
		.meas_quat_y(meas_quat_y), .meas_quat_z(meas_quat_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.torque_x(torque_x), .torque_y(torque_y), .torque_z(torque_z)
	);

	se3pid_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .sample_ok(sample_ok),
		.meas_pos_x(meas_pos_x), .meas_pos_y(meas_pos_y), .meas_pos_z(meas_pos_z),
		.meas_quat_w(meas_quat_w), .meas_quat_x(meas_quat_x),
		.meas_quat_y(meas_quat_y), .meas_quat_z(meas_quat_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.torque_x(torque_x), .torque_y(torque_y), .torque_z(torque_z),
		.fail_count(fail_count), .wrench_pending(wrench_pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Gap length: mostly zero to a few cycles, now and then a long pause.
	function automatic int pick_gap();
		if (no_gaps)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 120);
		return $urandom_range(0, 3);
	endfunction

	// Any quaternion element in the legal range -1.0 to +1.0.
	function automatic logic signed [15:0] rand_quat();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	// Positions either anywhere or close to the target, so the loop stays unsaturated.
	function automatic logic signed [31:0] rand_pos(logic signed [31:0] tgt);
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return tgt + 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
	endfunction

	// The watchdog count restarts whenever a channel moves a request, a result or a register access.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// The result side stalls in random bursts, except in gap-free stretches.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if (!no_gaps) begin
				out_ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end
		end
	end

	// Present one request and hold it until accepted, then idle for a random gap.
	// Called at a rising edge; returns at a rising edge.
	task automatic send_request(logic ok, logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, logic signed [15:0] qw, logic signed [15:0] qx,
			logic signed [15:0] qy, logic signed [15:0] qz);
		int gap;
		in_valid    <= 1'b1;
		sample_ok   <= ok;
		meas_pos_x  <= px;
		meas_pos_y  <= py;
		meas_pos_z  <= pz;
		meas_quat_w <= qw;
		meas_quat_x <= qx;
		meas_quat_y <= qy;
		meas_quat_z <= qz;
		do @(posedge clk); while (!in_ready);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(int n);
		for (int k = 0; k < n; k++)
			send_request($urandom_range(0, 9) != 0, rand_pos(cur_pos[0]), rand_pos(cur_pos[1]),
				rand_pos(cur_pos[2]), rand_quat(), rand_quat(), rand_quat(), rand_quat());
	endtask

	task automatic reg_write(reg_idx_t r, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every expected wrench is out, and give a request that returns
	// nothing time to leave the core, before touching the registers.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (wrench_pending != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic set_target(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, logic signed [15:0] qw, logic signed [15:0] qx,
			logic signed [15:0] qy, logic signed [15:0] qz, logic ok);
		wait_idle();
		reg_write(REG_POS_X, px);
		reg_write(REG_POS_Y, py);
		reg_write(REG_POS_Z, pz);
		reg_write(REG_QUAT_W, 32'(qw));
		reg_write(REG_QUAT_X, 32'(qx));
		reg_write(REG_QUAT_Y, 32'(qy));
		reg_write(REG_QUAT_Z, 32'(qz));
		reg_write(REG_TGT_VALID, {31'd0, ok});
		cur_pos = '{px, py, pz};
	endtask

	initial begin
		logic signed [31:0] pmax;
		logic signed [31:0] pmin;
		pmax = 32'h7fffffff;
		pmin = 32'h80000000;
		cur_pos = '{0, 0, 0};
		no_gaps = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		sample_ok = 1'b0;
		{meas_pos_x, meas_pos_y, meas_pos_z} = '0;
		{meas_quat_w, meas_quat_x, meas_quat_y, meas_quat_z} = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No target yet: good and failed samples both return nothing.
		send_request(1'b1, 65536, -65536, 0, 16384, 0, 0, 0);
		send_request(1'b0, 0, 0, 0, 16384, 0, 0, 0);

		// Identity target at the origin, then field extremes and odd quaternions.
		set_target(0, 0, 0, 16384, 0, 0, 0, 1'b1);
		send_request(1'b1, 0, 0, 0, 16384, 0, 0, 0);
		send_request(1'b1, pmax, pmin, pmax, 16384, 0, 0, 0);
		// Position error past the 32-bit range saturates.
		send_request(1'b1, pmin, pmax, pmin, -16384, 0, 0, 0);
		send_request(1'b1, 0, 0, 0, 0, 16384, 0, 0);
		send_request(1'b1, 0, 0, 0, 0, 0, 16384, 0);
		send_request(1'b1, 0, 0, 0, 0, 0, 0, 16384);
		send_request(1'b1, 0, 0, 0, 0, -16384, -16384, -16384);
		// Non-unit quaternions are used as given.
		send_request(1'b1, 1, -1, 0, 16384, 16384, 16384, 16384);
		send_request(1'b1, -1, 1, 0, -16384, -16384, -16384, -16384);
		send_request(1'b1, 0, 0, 0, 0, 0, 0, 0);
		// A failed sample with a valid target leaves all state alone.
		send_request(1'b0, pmax, pmax, pmax, 16384, 16384, 0, 0);
		send_request(1'b1, 0, 0, 0, 11585, 11585, 0, 0);

		// Extreme target, then waiting for a target again, which clears the integral.
		set_target(pmax, pmin, pmax, -16384, 16384, -16384, 16384, 1'b1);
		send_request(1'b1, pmin, pmax, pmin, 16384, -16384, 16384, -16384);
		send_request(1'b1, pmax, pmin, pmax, 0, 0, 0, 0);
		set_target(pmin, pmax, pmin, 16384, 0, 0, 0, 1'b0);
		send_request(1'b1, 0, 0, 0, 16384, 0, 0, 0);
		send_request(1'b0, 0, 0, 0, 16384, 0, 0, 0);
		set_target(pmin, pmax, pmin, 16384, 0, 0, 0, 1'b1);
		send_request(1'b1, 0, 0, 0, 16384, 0, 0, 0);
		send_request(1'b1, pmin, pmax, pmin, 16384, 0, 0, 0);

		// Random phases, each under a fresh target; some run with no idling at all.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 5)
				set_target($urandom, $urandom, $urandom, rand_quat(), rand_quat(),
					rand_quat(), rand_quat(), 1'b0);
			else if (ph == 2)
				set_target(pmin, pmax, 0, 16384, -16384, 16384, -16384, 1'b1);
			else
				set_target($urandom, $urandom, $urandom, rand_quat(), rand_quat(),
					rand_quat(), rand_quat(), 1'b1);
			no_gaps = (ph % 3 == 1);
			send_random(ph == 5 ? 20 : 110);
		end
		no_gaps = 1'b0;

		// Drain and let the core settle before the verdict.
		wait_idle();
		if (fail_count == 0 && wrench_pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
